>>> rtl/assert_macros.svh
// assertion macros used by the checker file bns_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is low
`define BNS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// concurrent assertion, also checked during reset
`define BNS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/bns_pkg.sv
// shared widths, defaults, codes and control structs for the bitmap search block
// no dependencies
package bns_pkg;

    localparam int SIZE_W  = 13;
    localparam int START_W = 12;
    localparam int INDEX_W = 6;
    localparam int DATA_W  = 64;

    localparam int DEF_WORD_BITS = 64;
    localparam int DEF_MAX_WORDS = 64;

    localparam int S_TDATA_W = ((INDEX_W + DATA_W + START_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SIZE_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic write;
        logic capture;
        logic mult;
        logic setup;
        logic eval;
        logic find;
        logic load_out;
    } bns_cmd_t;

    typedef struct packed {
        logic early;
        logic full;
        logic last;
        logic out_free;
    } bns_sts_t;

endpackage

>>> rtl/bitmap_next_zero_search.sv
// bitmap next-clear-bit search, top level; depends on bns_pkg, bns_ctrl, bns_dp
// write word: accepted in idle, no result. search: mult, setup, read, eval per word, then find
// if a clear bit is seen, then out, held until output is free; start past size skips to out
// the ram's single read port walks one word per cycle; input is ready again with the result
// aresetn (sync, active low) sets size to 4096 and empties the output; bitmap not cleared
module bitmap_next_zero_search #(
    parameter int WORD_BITS = bns_pkg::DEF_WORD_BITS,
    parameter int MAX_WORDS = bns_pkg::DEF_MAX_WORDS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bns_pkg::SIZE_W-1:0]      cfg_wdata,   // bitmap_size
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bns_pkg::S_TDATA_W-1:0]   s_tdata,     // word_index, word_data, start_bit
    input  logic                            s_tuser,     // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bns_pkg::M_TDATA_W-1:0]   m_tdata,     // first_zero
    output logic                            m_tuser      // none_found
);
    import bns_pkg::*;

    bns_cmd_t           cmd;
    bns_sts_t           sts;
    logic [SIZE_W-1:0]  first_zero;

    bns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bns_dp #(
        .WORD_BITS (WORD_BITS),
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .word_index (s_tdata[INDEX_W-1:0]),
        .word_data  (s_tdata[INDEX_W +: DATA_W]),
        .start_bit  (s_tdata[INDEX_W + DATA_W +: START_W]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .first_zero (first_zero),
        .none_found (m_tuser)
    );

    assign m_tdata = {{(M_TDATA_W - SIZE_W){1'b0}}, first_zero};

endmodule

>>> rtl/bns_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bns_ctrl.sv
// controller fsm: accepts words, sequences divide, setup, word walk and output load
// depends on bns_pkg
module bns_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              req_type,
    output logic              s_tready,
    input  bns_pkg::bns_sts_t sts,
    output bns_pkg::bns_cmd_t cmd
);
    import bns_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_SETUP,
        ST_READ,
        ST_EVAL,
        ST_FIND,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_type == REQ_SEARCH) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MULT;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = sts.early ? ST_OUT : ST_READ;
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (!sts.full) begin
                    state_next = ST_FIND;
                end else if (sts.last) begin
                    state_next = ST_OUT;
                end
            end
            ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/bns_dp.sv
// datapath: size register, bitmap ram, start split, word walk, clear-bit encode, output register
// depends on bns_pkg and bns_ram
module bns_dp #(
    parameter int WORD_BITS = bns_pkg::DEF_WORD_BITS,
    parameter int MAX_WORDS = bns_pkg::DEF_MAX_WORDS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [bns_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic [bns_pkg::INDEX_W-1:0]  word_index,
    input  logic [bns_pkg::DATA_W-1:0]   word_data,
    input  logic [bns_pkg::START_W-1:0]  start_bit,
    input  bns_pkg::bns_cmd_t            cmd,
    output bns_pkg::bns_sts_t            sts,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [bns_pkg::SIZE_W-1:0]   first_zero,
    output logic                         none_found
);
    import bns_pkg::*;

    localparam int ADDR_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int IDX_W   = $clog2(MAX_WORDS + 1);
    localparam int OFF_W   = $clog2(WORD_BITS);
    localparam int CAP     = MAX_WORDS * WORD_BITS;
    localparam int RECIP   = (1 << START_W) / WORD_BITS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = START_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
    localparam logic [START_W-1:0] WB_S     = START_W'(WORD_BITS);
    localparam logic [SIZE_W:0]    WB_L     = (SIZE_W + 1)'(WORD_BITS);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(MAX_WORDS - 1);
    localparam logic [START_W-1:0] MAX_W_S  = START_W'(MAX_WORDS);
    localparam logic [SIZE_W-1:0]  CAP_SAT  =
        (CAP > (1 << SIZE_W) - 1) ? {SIZE_W{1'b1}} : SIZE_W'(CAP);

    function automatic logic [OFF_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = OFF_W'(i);
            end
        end
        return pos;
    endfunction

    logic [SIZE_W-1:0]    size_cfg_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [START_W-1:0]   start_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [SIZE_W-1:0]    base_reg;
    logic                 first_reg;
    logic [WORD_BITS-1:0] hit_word_reg;
    logic [SIZE_W-1:0]    res_reg;
    logic                 m_valid_reg;
    logic [SIZE_W-1:0]    m_zero_reg;
    logic                 m_none_reg;

    logic [SIZE_W-1:0]    size_eff;
    logic [START_W-1:0]   quot;
    logic [START_W-1:0]   quot_w;
    logic [START_W-1:0]   rem;
    logic                 fix;
    logic [START_W-1:0]   quot_c;
    logic [START_W-1:0]   rem_c;
    logic [START_W-1:0]   base_c;
    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] word_w;
    logic [SIZE_W:0]      base_inc;
    logic [IDX_W-1:0]     idx_inc;
    logic [OFF_W-1:0]     hit_pos;
    logic [SIZE_W:0]      hit;
    logic                 ram_we;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    // effective size saturates at capacity
    assign size_eff = (size_cfg_reg > CAP_SAT) ? CAP_SAT : size_cfg_reg;

    // start split into word index and offset, quotient low by at most one
    assign quot   = START_W'(prod_reg[PROD_W-1:START_W]);
    assign quot_w = START_W'(quot * WB_S);
    assign rem    = start_reg - quot_w;
    assign fix    = (rem >= WB_S);
    assign quot_c = quot + START_W'(fix);
    assign rem_c  = fix ? (rem - WB_S) : rem;
    assign base_c = fix ? (quot_w + WB_S) : quot_w;

    // word walk
    assign low_mask = ({{(WORD_BITS - 1){1'b0}}, 1'b1} << off_reg) - 1'b1;
    assign word_w   = rd_data | (first_reg ? low_mask : '0);
    assign base_inc = {1'b0, base_reg} + WB_L;
    assign idx_inc  = idx_reg + 1'b1;

    assign hit_pos = lowest_clear(hit_word_reg);
    assign hit     = {1'b0, base_reg} + (SIZE_W + 1)'(hit_pos);

    assign sts.early    = ({1'b0, start_reg} >= size_reg) || (quot_c >= MAX_W_S);
    assign sts.full     = &word_w;
    assign sts.last     = (idx_reg == LAST_IDX) || (base_inc >= {1'b0, size_reg});
    assign sts.out_free = !m_valid_reg || m_tready;

    assign ram_we  = cmd.write && (int'(word_index) < MAX_WORDS);
    assign rd_addr = (cmd.eval && sts.full) ? ADDR_W'(idx_inc) : ADDR_W'(idx_reg);

    bns_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ADDR_W'(word_index)),
        .wr_data (word_data[WORD_BITS-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= SIZE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                size_cfg_reg <= cfg_wdata;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            start_reg <= start_bit;
            size_reg  <= size_eff;
        end
        if (cmd.mult) begin
            prod_reg <= start_reg * RECIP_C;
        end
        if (cmd.setup) begin
            idx_reg   <= IDX_W'(quot_c);
            off_reg   <= rem_c[OFF_W-1:0];
            base_reg  <= SIZE_W'(base_c);
            first_reg <= 1'b1;
            res_reg   <= size_reg;
        end
        if (cmd.eval) begin
            if (!sts.full) begin
                hit_word_reg <= word_w;
            end else if (!sts.last) begin
                idx_reg   <= idx_inc;
                base_reg  <= base_inc[SIZE_W-1:0];
                first_reg <= 1'b0;
            end
        end
        if (cmd.find) begin
            res_reg <= (hit < {1'b0, size_reg}) ? hit[SIZE_W-1:0] : size_reg;
        end
        if (cmd.load_out) begin
            m_zero_reg <= res_reg;
            m_none_reg <= (res_reg == size_reg);
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign first_zero = m_zero_reg;
    assign none_found = m_none_reg;

endmodule

>>> rtl/bns_checker.sv
// port-level checker for the bitmap search block, bound to the top level
// depends on bns_pkg and assert_macros.svh
`include "assert_macros.svh"

module bns_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bns_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    `BNS_ASSERT(a_search_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser |=> !s_tready, "search word accepted but input still ready")
    `BNS_ASSERT(a_write_ready, aclk, aresetn, s_tvalid && s_tready && !s_tuser |=> s_tready, "write word stalled the input")
    `BNS_ASSERT(a_result_busy, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result appeared while block was idle")
    `BNS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `BNS_ASSERT_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind bitmap_next_zero_search bns_checker u_bns_checker (.*);

>>> verif/tb_bitmap_next_zero_search.sv
`timescale 1ns / 100ps
// testbench for bitmap_next_zero_search: directed table, then random write/search traffic
// results are checked against table answers or an in-bench predictor of bitmap and search
// depends on bns_pkg and bitmap_next_zero_search
module tb_bitmap_next_zero_search;

    import bns_pkg::*;

    localparam int LIMIT = 1_000_000;
    localparam int CAP_BITS = DEF_MAX_WORDS * DEF_WORD_BITS;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] TOP_CLEAR = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {ROW_WORD, ROW_FIND, ROW_SIZE} row_kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0] first_zero;
        logic              none_found;
    } answer_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SIZE_W-1:0] arg;       // word index, start bit or size
        logic [63:0]       data;
        logic              typed;
        answer_t           answer;
    } row_t;

    localparam int ROWS = 24;
    localparam row_t PLAN [ROWS] = '{
        '{ROW_FIND, 13'd0,    64'd0,     1'b1, '{13'd4096, 1'b1}},
        '{ROW_WORD, 13'd0,    64'd0,     1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd0,    64'd0,     1'b1, '{13'd0,    1'b0}},
        '{ROW_WORD, 13'd0,    TOP_CLEAR, 1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd5,    64'd0,     1'b1, '{13'd63,   1'b0}},
        '{ROW_WORD, 13'd63,   TOP_CLEAR, 1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd64,   64'd0,     1'b1, '{13'd4095, 1'b0}},
        '{ROW_FIND, 13'd4095, 64'd0,     1'b1, '{13'd4095, 1'b0}},
        '{ROW_WORD, 13'd5,    ~64'd1,    1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd320,  64'd0,     1'b1, '{13'd320,  1'b0}},
        '{ROW_FIND, 13'd321,  64'd0,     1'b0, '{13'd0,    1'b0}},
        '{ROW_SIZE, 13'd100,  64'd0,     1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd0,    64'd0,     1'b1, '{13'd63,   1'b0}},
        '{ROW_FIND, 13'd64,   64'd0,     1'b1, '{13'd100,  1'b1}},
        '{ROW_FIND, 13'd4095, 64'd0,     1'b1, '{13'd100,  1'b1}},
        '{ROW_SIZE, 13'd0,    64'd0,     1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd0,    64'd0,     1'b1, '{13'd0,    1'b1}},
        '{ROW_SIZE, 13'd1,    64'd0,     1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd0,    64'd0,     1'b1, '{13'd1,    1'b1}},
        '{ROW_SIZE, 13'd8191, 64'd0,     1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd4095, 64'd0,     1'b1, '{13'd4095, 1'b0}},
        '{ROW_WORD, 13'd63,   ALL_ONES,  1'b0, '{13'd0,    1'b0}},
        '{ROW_FIND, 13'd4095, 64'd0,     1'b1, '{13'd4096, 1'b1}},
        '{ROW_FIND, 13'd0,    64'd0,     1'b0, '{13'd0,    1'b0}}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [SIZE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;     // word_index, word_data, start_bit
    logic                  s_tuser = 1'b0;   // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // first_zero
    logic                  m_tuser;          // none_found

    logic [63:0]       bitmap_copy [DEF_MAX_WORDS];
    logic [SIZE_W-1:0] size_copy = SIZE_RESET;
    answer_t           pending_answers [$];
    answer_t           got_want;
    int                error_count = 0;
    int                cycle_count = 0;
    int                src_idle = 10;
    int                dst_idle = 73;

    bitmap_next_zero_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb_bitmap_next_zero_search: errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected word: first_zero %0d none_found %0b",
                         $time, m_tdata[SIZE_W-1:0], m_tuser);
                error_count++;
            end else begin
                got_want = pending_answers.pop_front();
                if (m_tdata[SIZE_W-1:0] !== got_want.first_zero) begin
                    $display("%0t first_zero mismatch: expected %0d, got %0d",
                             $time, got_want.first_zero, m_tdata[SIZE_W-1:0]);
                    error_count++;
                end
                if (m_tuser !== got_want.none_found) begin
                    $display("%0t none_found mismatch: expected %0b, got %0b",
                             $time, got_want.none_found, m_tuser);
                    error_count++;
                end
            end
        end
    end

    function automatic answer_t predict_next_zero(input logic [START_W-1:0] start);
        int          eff;
        int          res;
        int          pos;
        int          first_idx;
        logic [63:0] w;
        answer_t     a;
        eff = (int'(size_copy) < CAP_BITS) ? int'(size_copy) : CAP_BITS;
        res = eff;
        first_idx = start / 64;
        if (start < eff) begin
            for (int idx = first_idx; idx < DEF_MAX_WORDS && idx * 64 < eff; idx++) begin
                w = bitmap_copy[idx];
                if (idx == first_idx)
                    w = w | ((64'd1 << start[5:0]) - 64'd1);
                if (w != ALL_ONES) begin
                    pos = 0;
                    while (w[pos])
                        pos++;
                    res = (idx * 64 + pos < eff) ? idx * 64 + pos : eff;
                    break;
                end
            end
        end
        a.first_zero = SIZE_W'(res);
        a.none_found = (res == eff);
        return a;
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        int          pick;
        pick = $urandom_range(0, 9);
        w = ALL_ONES;
        if (pick == 5 || pick == 6)
            w[$urandom_range(0, 63)] = 1'b0;
        else if (pick == 7)
            w = {$urandom, $urandom};
        else if (pick == 8)
            w = 64'd0;
        else if (pick == 9)
            w = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
        return w;
    endfunction

    task automatic send_request(input logic req, input logic [INDEX_W-1:0] idx,
                                input logic [63:0] data, input logic [START_W-1:0] start,
                                input logic typed, input answer_t typed_answer);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_TDATA_W - INDEX_W - DATA_W - START_W){1'b0}}, start, data, idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (req == REQ_WRITE)
            bitmap_copy[idx] = data;
        else if (typed)
            pending_answers.push_back(typed_answer);
        else
            pending_answers.push_back(predict_next_zero(start));
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] value);
        wait_quiet();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        size_copy = value;
    endtask

    initial begin
        int                eff;
        logic [SIZE_W-1:0] chunk_size;
        logic [START_W-1:0] start;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every word gets written before any search reads it
        for (int i = 0; i < DEF_MAX_WORDS; i++)
            send_request(REQ_WRITE, INDEX_W'(i), ALL_ONES, START_W'($urandom), 1'b0, '0);

        for (int i = 0; i < ROWS; i++) begin
            case (PLAN[i].kind)
                ROW_WORD: begin
                    send_request(REQ_WRITE, PLAN[i].arg[INDEX_W-1:0], PLAN[i].data, '0,
                                 1'b0, '0);
                end
                ROW_FIND: begin
                    send_request(REQ_SEARCH, '0, '0, PLAN[i].arg[START_W-1:0],
                                 PLAN[i].typed, PLAN[i].answer);
                end
                default: begin
                    set_size(PLAN[i].arg);
                end
            endcase
        end

        for (int chunk = 0; chunk < 9; chunk++) begin
            src_idle = (chunk < 3) ? 10 : (chunk < 6) ? 73 : 0;
            dst_idle = (chunk < 3) ? 73 : (chunk < 6) ? 10 : 0;
            case (chunk)
                0:       chunk_size = 13'd4096;
                1:       chunk_size = 13'd1;
                2:       chunk_size = 13'd8191;
                3:       chunk_size = 13'd0;
                4:       chunk_size = SIZE_W'($urandom_range(1, 4095));
                5:       chunk_size = 13'd4095;
                6:       chunk_size = 13'd64;
                7:       chunk_size = SIZE_W'($urandom_range(0, 8191));
                default: chunk_size = 13'd4096;
            endcase
            set_size(chunk_size);
            eff = (int'(size_copy) < CAP_BITS) ? int'(size_copy) : CAP_BITS;
            for (int n = 0; n < 96; n++) begin
                if ($urandom_range(0, 99) == 0)
                    wait_quiet();
                if ($urandom_range(0, 9) < 4) begin
                    send_request(REQ_WRITE, INDEX_W'($urandom_range(0, 63)), rand_word(),
                                 START_W'($urandom), 1'b0, '0);
                end else begin
                    if ($urandom_range(0, 1) == 0 || eff == 0)
                        start = START_W'($urandom_range(0, 4095));
                    else
                        start = START_W'($urandom_range(0, (eff > 4095) ? 4095 : eff));
                    send_request(REQ_SEARCH, INDEX_W'($urandom), {$urandom, $urandom}, start,
                                 1'b0, '0);
                end
            end
        end

        wait_quiet();
        if (error_count == 0)
            $display("tb_bitmap_next_zero_search: clean");
        else
            $display("tb_bitmap_next_zero_search: errors");
        $finish;
    end

endmodule
